[src/flat_bottom_position_restraint_top_assert.svh]
// Assertion macros shared by the flat-bottom restraint RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef FLAT_BOTTOM_POSITION_RESTRAINT_TOP_ASSERT_SVH
`define FLAT_BOTTOM_POSITION_RESTRAINT_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FBPR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FBPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/fbpr_pkg.sv]
// Shared constants for the flat-bottom position restraint block.
// No dependencies; used by the top level and the divider pipeline.
package fbpr_pkg;

    localparam int LIM_W     = 31;
    localparam int ENERGY_W  = 47;
    localparam int NUM_LANES = 3;
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam cfg_idx_t CFG_REF_X    = 3'd0;
    localparam cfg_idx_t CFG_REF_Y    = 3'd1;
    localparam cfg_idx_t CFG_REF_Z    = 3'd2;
    localparam cfg_idx_t CFG_MAX_DISP = 3'd3;
    localparam cfg_idx_t CFG_FORCE_K  = 3'd4;

endpackage

[src/fbpr_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Carries a sideband word alongside; no package dependency.
module fbpr_sqrt #(
    parameter int RW     = 33,
    parameter int SIDE_W = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [2*RW-1:0]     radicand,
    input  logic [SIDE_W-1:0]   side,
    output logic                out_valid,
    output logic [RW-1:0]       root,
    output logic [SIDE_W-1:0]   side_out
);

    logic              v_reg    [RW];
    logic [RW-1:0]     root_reg [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [2*RW-1:0]   rad_reg  [RW];
    logic [SIDE_W-1:0] side_reg [RW];

    for (genvar s = 0; s < RW; s++) begin : g_stage
        logic              v_prev;
        logic [RW-1:0]     root_prev;
        logic [RW+1:0]     rem_prev;
        logic [2*RW-1:0]   rad_prev;
        logic [SIDE_W-1:0] side_prev;
        logic [RW+1:0]     rem_sh;
        logic [RW+1:0]     trial;
        logic              take;
        logic [RW+1:0]     rem_next;
        logic [RW-1:0]     root_next;

        if (s == 0) begin : g_first
            assign v_prev    = in_valid;
            assign root_prev = '0;
            assign rem_prev  = '0;
            assign rad_prev  = radicand;
            assign side_prev = side;
        end else begin : g_rest
            assign v_prev    = v_reg[s-1];
            assign root_prev = root_reg[s-1];
            assign rem_prev  = rem_reg[s-1];
            assign rad_prev  = rad_reg[s-1];
            assign side_prev = side_reg[s-1];
        end

        // Bring down the next two radicand bits and try the next root bit.
        assign rem_sh    = {rem_prev[RW-1:0], rad_prev[2*RW-1:2*RW-2]};
        assign trial     = {root_prev, 2'b01};
        assign take      = (rem_sh >= trial);
        assign rem_next  = take ? (rem_sh - trial) : rem_sh;
        assign root_next = {root_prev[RW-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= v_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                root_reg[s] <= root_next;
                rem_reg[s]  <= rem_next;
                rad_reg[s]  <= {rad_prev[2*RW-3:0], 2'b00};
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = v_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign side_out  = side_reg[RW-1];

endmodule

[src/fbpr_div.sv]
// Pipelined restoring divider for the three gradient lanes, one quotient bit per stage after the first.
// Uses fbpr_pkg for the lane count and the shared assertion macros.
`include "flat_bottom_position_restraint_top_assert.svh"

module fbpr_div #(
    parameter int L      = 32,
    parameter int NW     = 97,
    parameter int DENW   = 49,
    parameter int SIDE_W = 8,
    localparam int QW    = L + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    en,
    input  logic                                    in_valid,
    input  logic [fbpr_pkg::NUM_LANES-1:0][NW-1:0]  num,
    input  logic [DENW-1:0]                         den,
    input  logic [SIDE_W-1:0]                       side,
    output logic                                    out_valid,
    output logic [fbpr_pkg::NUM_LANES-1:0][QW-1:0]  quo,
    output logic [SIDE_W-1:0]                       side_out
);

    localparam int NL = fbpr_pkg::NUM_LANES;
    localparam int NS = L + 1;
    localparam int HW = NW - L;
    localparam int CW = (HW > DENW) ? HW : DENW;

    logic              v_reg    [NS];
    logic [DENW-1:0]   den_reg  [NS];
    logic [SIDE_W-1:0] side_reg [NS];
    logic [DENW-1:0]   rem_reg  [NL][NS];
    logic [L-1:0]      low_reg  [NL][NS];
    logic [L-1:0]      q_reg    [NL][NS];
    logic              ovf_reg  [NL][NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s] <= (s == 0) ? in_valid : v_reg[(s == 0) ? 0 : s-1];
            end
        end

        if (s == 0) begin : g_init
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[0]  <= den;
                    side_reg[0] <= side;
                end
            end

            for (genvar l = 0; l < NL; l++) begin : g_lane
                logic [CW-1:0] hi_ext;
                logic          ovf_next;

                // A quotient of 2^L or more saturates the gradient anyway.
                assign hi_ext   = CW'(num[l][NW-1:L]);
                assign ovf_next = (hi_ext >= CW'(den));

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        ovf_reg[l][0] <= ovf_next;
                        rem_reg[l][0] <= DENW'(hi_ext);
                        low_reg[l][0] <= num[l][L-1:0];
                        q_reg[l][0]   <= '0;
                    end
                end
            end
        end else begin : g_step
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    den_reg[s]  <= den_reg[s-1];
                    side_reg[s] <= side_reg[s-1];
                end
            end

            for (genvar l = 0; l < NL; l++) begin : g_lane
                logic [DENW:0]   rem_sh;
                logic [DENW:0]   diff;
                logic            take;
                logic [DENW-1:0] rem_next;

                assign rem_sh   = {rem_reg[l][s-1], low_reg[l][s-1][L-1]};
                assign diff     = rem_sh - {1'b0, den_reg[s-1]};
                assign take     = (rem_sh >= {1'b0, den_reg[s-1]});
                assign rem_next = take ? diff[DENW-1:0] : rem_sh[DENW-1:0];

                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        ovf_reg[l][s] <= ovf_reg[l][s-1];
                        rem_reg[l][s] <= rem_next;
                        low_reg[l][s] <= {low_reg[l][s-1][L-2:0], 1'b0};
                        q_reg[l][s]   <= {q_reg[l][s-1][L-2:0], take};
                    end
                end
            end
        end
    end

    for (genvar l = 0; l < NL; l++) begin : g_out
        assign quo[l] = ovf_reg[l][NS-1] ? {1'b1, {L{1'b0}}} : {1'b0, q_reg[l][NS-1]};
    end

    assign out_valid = v_reg[NS-1];
    assign side_out  = side_reg[NS-1];

    `FBPR_ASSERT_SAME(a_rem_below_den, v_reg[NS-1] && !ovf_reg[0][NS-1],
        rem_reg[0][NS-1] < den_reg[NS-1], "divider remainder not below divisor")

endmodule

[src/flat_bottom_position_restraint_top.sv]
// Top level of the flat-bottom harmonic position restraint pipeline.
// Depends on fbpr_pkg, fbpr_sqrt, fbpr_div and the assertion macro header.
//
//  Channel   Direction  Handshake               Payload
//  config    in         cfg_write               cfg_index, cfg_data
//  request   in         in_valid / in_stall     pos_x/y/z, grad_in_x/y/z
//  result    out        out_valid / out_stall   energy, grad_out_x/y/z, restrained, saturated
//
// One request enters every cycle unless in_stall is high; the square root and divider
// pipelines each resolve one bit per stage.
// Reset clears the configuration registers and every stage valid bit.
// The whole pipeline holds while a result waits under out_stall, so in_stall follows it.
`include "flat_bottom_position_restraint_top_assert.svh"

module flat_bottom_position_restraint_top #(
    parameter int COORD_BITS = 32,
    parameter int FRAC_BITS  = 16,
    localparam int CFG_DW    = (COORD_BITS > fbpr_pkg::LIM_W) ? COORD_BITS : fbpr_pkg::LIM_W
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [fbpr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]                 cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic signed [COORD_BITS-1:0]      pos_z,
    input  logic signed [COORD_BITS-1:0]      grad_in_x,
    input  logic signed [COORD_BITS-1:0]      grad_in_y,
    input  logic signed [COORD_BITS-1:0]      grad_in_z,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [fbpr_pkg::ENERGY_W-1:0]     energy,
    output logic signed [COORD_BITS-1:0]      grad_out_x,
    output logic signed [COORD_BITS-1:0]      grad_out_y,
    output logic signed [COORD_BITS-1:0]      grad_out_z,
    output logic                              restrained,
    output logic                              saturated
);

    localparam int C     = COORD_BITS;
    localparam int F     = FRAC_BITS;
    localparam int NL    = fbpr_pkg::NUM_LANES;
    localparam int KW    = fbpr_pkg::LIM_W;
    localparam int EGW   = fbpr_pkg::ENERGY_W;
    localparam int DW    = C + 1;
    localparam int RW    = C + 1;
    localparam int SQW   = 2 * C;
    localparam int SUMW  = 2 * RW;
    localparam int EW    = RW;
    localparam int CMPW  = (RW > KW) ? RW : KW;
    localparam int PW    = KW + EW;
    localparam int SPLIT = 32;
    localparam int PHW   = PW - SPLIT;
    localparam int ELW   = SPLIT + EW;
    localparam int EHW   = PHW + EW;
    localparam int EPW   = PW + EW;
    localparam int NLW   = SPLIT + C;
    localparam int NHW   = PHW + C;
    localparam int NW    = PW + C;
    localparam int DENW  = RW + F;
    localparam int QW    = C + 1;
    localparam int ESH   = 2 * F + 1;
    localparam int ETOP  = ESH + EGW;
    localparam int EPADW = (EPW > ETOP) ? EPW : ETOP + 1;

    // Per-atom geometry that rides alongside the distance calculation.
    typedef struct packed {
        logic [NL-1:0][C-1:0] mag;
        logic [NL-1:0]        neg;
        logic [NL-1:0][C-1:0] gin;
    } geo_t;

    // What the final stage still needs once the divider is done.
    typedef struct packed {
        logic [EGW-1:0]       energy;
        logic                 esat;
        logic                 restr;
        logic [NL-1:0]        neg;
        logic [NL-1:0][C-1:0] gin;
    } tail_t;

    // Configuration registers.
    logic signed [C-1:0] ref_reg [NL];
    logic [KW-1:0]       maxd_reg;
    logic [KW-1:0]       k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg[0] <= '0;
            ref_reg[1] <= '0;
            ref_reg[2] <= '0;
            maxd_reg   <= '0;
            k_reg      <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                fbpr_pkg::CFG_REF_X:    ref_reg[0] <= cfg_data[C-1:0];
                fbpr_pkg::CFG_REF_Y:    ref_reg[1] <= cfg_data[C-1:0];
                fbpr_pkg::CFG_REF_Z:    ref_reg[2] <= cfg_data[C-1:0];
                fbpr_pkg::CFG_MAX_DISP: maxd_reg   <= cfg_data[KW-1:0];
                fbpr_pkg::CFG_FORCE_K:  k_reg      <= cfg_data[KW-1:0];
                default:                ;
            endcase
        end
    end

    // The whole pipeline advances together unless a finished result is held back.
    logic adv;
    logic out_valid_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    // Stage A: offset from the reference point, split into sign and magnitude.
    logic signed [C-1:0]  pos_a  [NL];
    logic signed [C-1:0]  gin_a  [NL];
    logic signed [DW-1:0] d_a    [NL];
    logic signed [DW-1:0] absd_a [NL];
    geo_t                 a_geo_next;
    geo_t                 a_geo_reg;
    logic                 a_valid_reg;

    assign pos_a[0] = pos_x;
    assign pos_a[1] = pos_y;
    assign pos_a[2] = pos_z;
    assign gin_a[0] = grad_in_x;
    assign gin_a[1] = grad_in_y;
    assign gin_a[2] = grad_in_z;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            d_a[i]               = DW'(pos_a[i]) - DW'(ref_reg[i]);
            absd_a[i]            = d_a[i][DW-1] ? -d_a[i] : d_a[i];
            a_geo_next.mag[i]    = absd_a[i][C-1:0];
            a_geo_next.neg[i]    = d_a[i][DW-1];
            a_geo_next.gin[i]    = gin_a[i];
        end
    end

    // Stage B: squares of the three offsets.
    logic [SQW-1:0] b_sq_next [NL];
    logic [SQW-1:0] b_sq_reg  [NL];
    geo_t           b_geo_reg;
    logic           b_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            b_sq_next[i] = SQW'(a_geo_reg.mag[i]) * SQW'(a_geo_reg.mag[i]);
        end
    end

    // Stage C: squared distance.
    logic [SUMW-1:0] c_sum_next;
    logic [SUMW-1:0] c_sum_reg;
    geo_t            c_geo_reg;
    logic            c_valid_reg;

    assign c_sum_next = SUMW'(b_sq_reg[0]) + SUMW'(b_sq_reg[1]) + SUMW'(b_sq_reg[2]);

    // Square root pipeline gives the floor of the distance.
    logic          s_valid;
    logic [RW-1:0] s_root;
    geo_t          s_geo;

    fbpr_sqrt #(
        .RW     (RW),
        .SIDE_W ($bits(geo_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid_reg),
        .radicand  (c_sum_reg),
        .side      (c_geo_reg),
        .out_valid (s_valid),
        .root      (s_root),
        .side_out  (s_geo)
    );

    // Stage E: compare against the free radius and form the excess and divisor.
    logic [CMPW-1:0] dist_ext;
    logic [CMPW-1:0] maxd_ext;
    logic [CMPW-1:0] excess_full;
    logic [RW-1:0]   dist_cl;
    logic            e_restr_reg;
    logic [EW-1:0]   e_excess_reg;
    logic [DENW-1:0] e_den_reg;
    geo_t            e_geo_reg;
    logic            e_valid_reg;

    assign dist_ext    = CMPW'(s_root);
    assign maxd_ext    = CMPW'(maxd_reg);
    assign excess_full = dist_ext - maxd_ext;
    // A zero distance divides by one LSB; it can never be restrained anyway.
    assign dist_cl     = (s_root == '0) ? RW'(1) : s_root;

    // Stage P: k times the excess.
    logic [PW-1:0]   p_pre_reg;
    logic [EW-1:0]   p_excess_reg;
    logic            p_restr_reg;
    logic [DENW-1:0] p_den_reg;
    geo_t            p_geo_reg;
    logic            p_valid_reg;

    // Stage Q: partial products of the energy and of the three numerators.
    logic [ELW-1:0]  q_elo_reg;
    logic [EHW-1:0]  q_ehi_reg;
    logic [NLW-1:0]  q_nlo_next [NL];
    logic [NHW-1:0]  q_nhi_next [NL];
    logic [NLW-1:0]  q_nlo_reg  [NL];
    logic [NHW-1:0]  q_nhi_reg  [NL];
    logic            q_restr_reg;
    logic [DENW-1:0] q_den_reg;
    geo_t            q_geo_reg;
    logic            q_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            q_nlo_next[i] = NLW'(p_pre_reg[SPLIT-1:0]) * NLW'(p_geo_reg.mag[i]);
            q_nhi_next[i] = NHW'(p_pre_reg[PW-1:SPLIT]) * NHW'(p_geo_reg.mag[i]);
        end
    end

    // Stage R: full products.
    logic [EPW-1:0]             r_eprod_reg;
    logic [NL-1:0][NW-1:0]      r_num_next;
    logic [NL-1:0][NW-1:0]      r_num_reg;
    logic                       r_restr_reg;
    logic [DENW-1:0]            r_den_reg;
    geo_t                       r_geo_reg;
    logic                       r_valid_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            r_num_next[i] = (NW'(q_nhi_reg[i]) << SPLIT) + NW'(q_nlo_reg[i]);
        end
    end

    // Energy is a fixed shift of the product, clipped at the top of its range.
    logic [EPADW-1:0] epad;
    tail_t            r_tail;

    assign epad          = EPADW'(r_eprod_reg);
    assign r_tail.esat   = |epad[EPADW-1:ETOP];
    assign r_tail.energy = r_tail.esat ? {EGW{1'b1}} : epad[ETOP-1:ESH];
    assign r_tail.restr  = r_restr_reg;
    assign r_tail.neg    = r_geo_reg.neg;
    assign r_tail.gin    = r_geo_reg.gin;

    // Divider pipeline: k*excess*|d| over dist, one lane per axis.
    logic                  v_valid;
    logic [NL-1:0][QW-1:0] v_quo;
    tail_t                 v_tail;

    fbpr_div #(
        .L      (C),
        .NW     (NW),
        .DENW   (DENW),
        .SIDE_W ($bits(tail_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (r_valid_reg),
        .num       (r_num_reg),
        .den       (r_den_reg),
        .side      (r_tail),
        .out_valid (v_valid),
        .quo       (v_quo),
        .side_out  (v_tail)
    );

    // Final stage: for restrained requests, signed accumulate into the running gradient with saturation.
    logic signed [C+1:0] gsum     [NL];
    logic signed [C+1:0] qext     [NL];
    logic [2:0]          gtop     [NL];
    logic [NL-1:0]       gclip;
    logic [C-1:0]        grad_next [NL];
    logic [EGW-1:0]      out_energy_next;
    logic                out_sat_next;
    logic [EGW-1:0]      out_energy_reg;
    logic [C-1:0]        out_grad_reg [NL];
    logic                out_restr_reg;
    logic                out_sat_reg;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            qext[i] = $signed({1'b0, v_quo[i]});
            gsum[i] = $signed({{2{v_tail.gin[i][C-1]}}, v_tail.gin[i]});
            gsum[i] = v_tail.neg[i] ? (gsum[i] - qext[i]) : (gsum[i] + qext[i]);
            gtop[i] = gsum[i][C+1:C-1];
            gclip[i] = !(gtop[i] == 3'b000 || gtop[i] == 3'b111);
            if (!v_tail.restr)
            begin
                grad_next[i] = v_tail.gin[i];
            end
            else if (gclip[i])
            begin
                grad_next[i] = gsum[i][C+1] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
            end
            else
            begin
                grad_next[i] = gsum[i][C-1:0];
            end
        end
        out_energy_next = v_tail.restr ? v_tail.energy : '0;
        out_sat_next    = v_tail.restr && (v_tail.esat || (|gclip));
    end

    // Stage valid bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            p_valid_reg   <= 1'b0;
            q_valid_reg   <= 1'b0;
            r_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            e_valid_reg   <= s_valid;
            p_valid_reg   <= e_valid_reg;
            q_valid_reg   <= p_valid_reg;
            r_valid_reg   <= q_valid_reg;
            out_valid_reg <= v_valid;
        end
    end

    // Stage payloads.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_geo_reg      <= a_geo_next;
            b_sq_reg       <= b_sq_next;
            b_geo_reg      <= a_geo_reg;
            c_sum_reg      <= c_sum_next;
            c_geo_reg      <= b_geo_reg;
            e_restr_reg    <= (dist_ext > maxd_ext);
            e_excess_reg   <= excess_full[EW-1:0];
            e_den_reg      <= {dist_cl, {F{1'b0}}};
            e_geo_reg      <= s_geo;
            p_pre_reg      <= PW'(k_reg) * PW'(e_excess_reg);
            p_excess_reg   <= e_excess_reg;
            p_restr_reg    <= e_restr_reg;
            p_den_reg      <= e_den_reg;
            p_geo_reg      <= e_geo_reg;
            q_elo_reg      <= ELW'(p_pre_reg[SPLIT-1:0]) * ELW'(p_excess_reg);
            q_ehi_reg      <= EHW'(p_pre_reg[PW-1:SPLIT]) * EHW'(p_excess_reg);
            q_nlo_reg      <= q_nlo_next;
            q_nhi_reg      <= q_nhi_next;
            q_restr_reg    <= p_restr_reg;
            q_den_reg      <= p_den_reg;
            q_geo_reg      <= p_geo_reg;
            r_eprod_reg    <= (EPW'(q_ehi_reg) << SPLIT) + EPW'(q_elo_reg);
            r_num_reg      <= r_num_next;
            r_restr_reg    <= q_restr_reg;
            r_den_reg      <= q_den_reg;
            r_geo_reg      <= q_geo_reg;
            out_energy_reg <= out_energy_next;
            out_grad_reg   <= grad_next;
            out_restr_reg  <= v_tail.restr;
            out_sat_reg    <= out_sat_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign energy     = out_energy_reg;
    assign grad_out_x = out_grad_reg[0];
    assign grad_out_y = out_grad_reg[1];
    assign grad_out_z = out_grad_reg[2];
    assign restrained = out_restr_reg;
    assign saturated  = out_sat_reg;

    `FBPR_ASSERT_SAME(a_free_is_quiet, out_valid_reg && !out_restr_reg,
        out_energy_reg == '0 && !out_sat_reg, "unrestrained result carries energy or clip")
    `FBPR_ASSERT_SAME(a_excess_nonzero, e_valid_reg && e_restr_reg,
        e_excess_reg != '0, "restrained request with zero excess")
    `FBPR_ASSERT_NEXT(a_request_enters, in_valid && adv,
        a_valid_reg, "accepted request did not enter the first stage")

endmodule
